>>> rtl/gmr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and label arithmetic for the grid maze router.
package gmr_pkg;

	localparam int unsigned DIM          = 64;
	localparam int unsigned DIM_W        = 6;
	localparam int unsigned SIZE_W       = DIM_W + 1;
	localparam int unsigned CELL_W       = 2 * DIM_W;
	localparam int unsigned CELL_COUNT   = DIM * DIM;
	localparam int unsigned MAX_SEGMENTS = 256;
	localparam int unsigned SEG_AW       = 8;
	localparam int unsigned SEG_CNT_W    = SEG_AW + 1;
	localparam int unsigned FIFO_DEPTH   = 2;

	localparam logic [1:0] LAB_NONE = 2'd3;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_BLOCK,
		CMD_ROUTE,
		CMD_READ
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_NO_ROUTE,
		ST_PIN_OUT,
		ST_BAD_INDEX,
		ST_TRUNC
	} status_t;

	typedef enum logic [1:0] {
		REG_GRID_HEIGHT,
		REG_GRID_WIDTH,
		REG_SPARE_A,
		REG_SPARE_B
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIR_UP,
		DIR_LEFT,
		DIR_DOWN,
		DIR_RIGHT
	} dir_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_CLEAR, S_BLOCK, S_LCLR, S_SEED, S_FPOP, S_FCUR,
		S_FLAB, S_FNBR, S_FCHK, S_MARK, S_BTL, S_BTW, S_BTN, S_BTC, S_FIN,
		S_RDA, S_RDW, S_RES
	} eng_state_t;

	typedef struct packed {
		cmd_t               op;
		logic [DIM_W-1:0]   ra;
		logic [DIM_W-1:0]   ca;
		logic [DIM_W-1:0]   rb;
		logic [DIM_W-1:0]   cb;
		logic [SIZE_W-1:0]  re;
		logic [SIZE_W-1:0]  ce;
		logic               blk_empty;
		logic               pin_bad;
		logic [SEG_AW-1:0]  seg_index;
	} cmd_item_t;

	typedef struct packed {
		logic [DIM_W-1:0] sr;
		logic [DIM_W-1:0] sc;
		logic [DIM_W-1:0] er;
		logic [DIM_W-1:0] ec;
	} seg_t;

	typedef struct packed {
		status_t              status;
		logic [SEG_CNT_W-1:0] count;
		seg_t                 seg;
	} res_t;

	localparam int unsigned CMD_ITEM_W = $bits(cmd_item_t);
	localparam int unsigned RES_W      = $bits(res_t);

	function automatic logic [1:0] lab_next(input logic [1:0] l);
		case (l)
			2'd0:    lab_next = 2'd1;
			2'd1:    lab_next = 2'd2;
			2'd2:    lab_next = 2'd0;
			default: lab_next = 2'd1;
		endcase
	endfunction

	function automatic logic [1:0] lab_prev(input logic [1:0] l);
		case (l)
			2'd0:    lab_prev = 2'd2;
			2'd1:    lab_prev = 2'd0;
			2'd2:    lab_prev = 2'd1;
			default: lab_prev = 2'd2;
		endcase
	endfunction

endpackage

>>> rtl/grid_maze_router.sv
`timescale 1ns / 1ps
// Grid maze router top level: front decode, command queue, engine, result queue.
// Reset: asynchronous; a clearing pass of the obstacle map follows, full held high.
// Route: a label sweep, then a breadth-first flood from the source cell,
// then a backtrack that marks the path cells; one command at a time.
// The engine's label and map memories, each with one read and one write port, set the rate; two-entry queues each side.
module grid_maze_router #(
	parameter int unsigned QUEUE_DEPTH = gmr_pkg::FIFO_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      command,
	input  logic [gmr_pkg::DIM_W-1:0]       row_a,
	input  logic [gmr_pkg::DIM_W-1:0]       col_a,
	input  logic [gmr_pkg::DIM_W-1:0]       row_b,
	input  logic [gmr_pkg::DIM_W-1:0]       col_b,
	input  logic [gmr_pkg::SIZE_W-1:0]      rect_rows,
	input  logic [gmr_pkg::SIZE_W-1:0]      rect_cols,
	input  logic [gmr_pkg::SEG_AW-1:0]      seg_index,
	output logic                            empty,
	input  logic                            pop,
	output logic [2:0]                      status,
	output logic [gmr_pkg::SEG_CNT_W-1:0]   segment_count,
	output logic [gmr_pkg::DIM_W-1:0]       seg_start_row,
	output logic [gmr_pkg::DIM_W-1:0]       seg_start_col,
	output logic [gmr_pkg::DIM_W-1:0]       seg_end_row,
	output logic [gmr_pkg::DIM_W-1:0]       seg_end_col,
	input  logic                            cfg_write,
	input  logic [1:0]                      cfg_index,
	input  logic [gmr_pkg::SIZE_W-1:0]      cfg_data
);
	gmr_pkg::cmd_item_t         fe_item, q_item;
	gmr_pkg::res_t              eng_res, out_res;
	logic [gmr_pkg::SIZE_W-1:0] h, w;
	logic                       cmd_full, cmd_empty, cmd_pop;
	logic                       res_full, res_push, init_busy;

	assign full = cmd_full || init_busy;

	gmr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.command   (command),
		.row_a     (row_a),
		.col_a     (col_a),
		.row_b     (row_b),
		.col_b     (col_b),
		.rect_rows (rect_rows),
		.rect_cols (rect_cols),
		.seg_index (seg_index),
		.item      (fe_item),
		.h         (h),
		.w         (w)
	);

	gmr_fifo #(
		.WIDTH (gmr_pkg::CMD_ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && !full),
		.wr_data (fe_item),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (q_item),
		.empty   (cmd_empty)
	);

	gmr_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.h         (h),
		.w         (w),
		.cmd_empty (cmd_empty),
		.cmd_item  (q_item),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (eng_res),
		.init_busy (init_busy)
	);

	gmr_fifo #(
		.WIDTH (gmr_pkg::RES_W),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (eng_res),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (out_res),
		.empty   (empty)
	);

	assign status        = out_res.status;
	assign segment_count = out_res.count;
	assign seg_start_row = out_res.seg.sr;
	assign seg_start_col = out_res.seg.sc;
	assign seg_end_row   = out_res.seg.er;
	assign seg_end_col   = out_res.seg.ec;
endmodule

>>> rtl/gmr_fifo.sv
`timescale 1ns / 1ps
// Small first-in first-out queue between the router's parts.
module gmr_fifo #(
	parameter int unsigned WIDTH = gmr_pkg::CMD_ITEM_W,
	parameter int unsigned DEPTH = gmr_pkg::FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule

>>> rtl/gmr_front.sv
`timescale 1ns / 1ps
// Front end: grid size registers and decoding of incoming commands.
module gmr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [1:0]                    cfg_index,
	input  logic [gmr_pkg::SIZE_W-1:0]    cfg_data,
	input  logic [1:0]                    command,
	input  logic [gmr_pkg::DIM_W-1:0]     row_a,
	input  logic [gmr_pkg::DIM_W-1:0]     col_a,
	input  logic [gmr_pkg::DIM_W-1:0]     row_b,
	input  logic [gmr_pkg::DIM_W-1:0]     col_b,
	input  logic [gmr_pkg::SIZE_W-1:0]    rect_rows,
	input  logic [gmr_pkg::SIZE_W-1:0]    rect_cols,
	input  logic [gmr_pkg::SEG_AW-1:0]    seg_index,
	output gmr_pkg::cmd_item_t            item,
	output logic [gmr_pkg::SIZE_W-1:0]    h,
	output logic [gmr_pkg::SIZE_W-1:0]    w
);
	logic [gmr_pkg::SIZE_W-1:0] height_q, width_q;
	logic [gmr_pkg::SIZE_W:0]   re_sum, ce_sum;
	logic                       a_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= gmr_pkg::SIZE_W'(gmr_pkg::DIM);
			width_q  <= gmr_pkg::SIZE_W'(gmr_pkg::DIM);
		end else if (cfg_write) begin
			case (gmr_pkg::reg_idx_t'(cfg_index))
				gmr_pkg::REG_GRID_HEIGHT: height_q <= cfg_data;
				gmr_pkg::REG_GRID_WIDTH:  width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (height_q == '0) begin
			h = gmr_pkg::SIZE_W'(1);
		end else if (height_q > gmr_pkg::SIZE_W'(gmr_pkg::DIM)) begin
			h = gmr_pkg::SIZE_W'(gmr_pkg::DIM);
		end else begin
			h = height_q;
		end
		if (width_q == '0) begin
			w = gmr_pkg::SIZE_W'(1);
		end else if (width_q > gmr_pkg::SIZE_W'(gmr_pkg::DIM)) begin
			w = gmr_pkg::SIZE_W'(gmr_pkg::DIM);
		end else begin
			w = width_q;
		end
	end

	assign re_sum = {2'b00, row_a} + {1'b0, rect_rows};
	assign ce_sum = {2'b00, col_a} + {1'b0, rect_cols};
	assign a_in   = ({1'b0, row_a} < h) && ({1'b0, col_a} < w);

	always_comb begin
		item.op        = gmr_pkg::cmd_t'(command);
		item.ra        = row_a;
		item.ca        = col_a;
		item.rb        = row_b;
		item.cb        = col_b;
		item.re        = (re_sum > {1'b0, h}) ? h : re_sum[gmr_pkg::SIZE_W-1:0];
		item.ce        = (ce_sum > {1'b0, w}) ? w : ce_sum[gmr_pkg::SIZE_W-1:0];
		item.blk_empty = !a_in || (rect_rows == '0) || (rect_cols == '0);
		item.pin_bad   = !a_in || ({1'b0, row_b} >= h) || ({1'b0, col_b} >= w);
		item.seg_index = seg_index;
	end
endmodule

>>> rtl/gmr_engine.sv
`timescale 1ns / 1ps
// Back end: map sweeps, breadth-first flood, backtrack and segment store.
module gmr_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [gmr_pkg::SIZE_W-1:0]    h,
	input  logic [gmr_pkg::SIZE_W-1:0]    w,
	input  logic                          cmd_empty,
	input  gmr_pkg::cmd_item_t            cmd_item,
	output logic                          cmd_pop,
	input  logic                          res_full,
	output logic                          res_push,
	output gmr_pkg::res_t                 res_data,
	output logic                          init_busy
);
	localparam int unsigned CW  = gmr_pkg::CELL_W;
	localparam int unsigned DW  = gmr_pkg::DIM_W;
	localparam int unsigned PW  = CW + 1;
	localparam int unsigned NW  = gmr_pkg::SEG_CNT_W;

	logic                  obs_mem [gmr_pkg::CELL_COUNT];
	logic [1:0]            lab_mem [gmr_pkg::CELL_COUNT];
	logic [CW-1:0]         q_mem   [gmr_pkg::CELL_COUNT];
	gmr_pkg::seg_t         st_mem  [gmr_pkg::MAX_SEGMENTS];

	logic                  obs_rd_q;
	logic [1:0]            lab_rd_q;
	logic [CW-1:0]         q_rd_q;
	gmr_pkg::seg_t         st_rd_q;

	logic                  obs_we, lab_we, q_we, st_we;
	logic [CW-1:0]         obs_waddr, lab_waddr, rd_cell;
	logic                  obs_wdata;
	logic [1:0]            lab_wdata;
	logic [CW-1:0]         q_wdata;
	gmr_pkg::seg_t         st_wdata;

	gmr_pkg::eng_state_t   state_q, state_d;
	gmr_pkg::cmd_item_t    it_q, it_d;
	gmr_pkg::res_t         res_q, res_d;
	gmr_pkg::seg_t         seg_q, seg_d;
	logic [CW-1:0]         cnt_q, cnt_d, cur_q, cur_d, n_q, n_d;
	logic [PW-1:0]         head_q, head_d, tail_q, tail_d, guard_q, guard_d;
	logic [1:0]            nl_q, nl_d, want_q, want_d;
	logic [2:0]            k_q, k_d;
	logic [DW-1:0]         r_q, r_d, c_q, c_d, pr_q, pr_d, pc_q, pc_d;
	logic [NW-1:0]         total_q, total_d, stored_q, stored_d;
	logic                  found_q, found_d, ovf_q, ovf_d;

	logic [CW-1:0]         src, dst;
	gmr_pkg::dir_t         dir;
	logic [DW-1:0]         base_r, base_c, nb_r, nb_c;
	logic                  nb_ok, seg_room;

	assign src       = {it_q.ra, it_q.ca};
	assign dst       = {it_q.rb, it_q.cb};
	assign init_busy = (state_q == gmr_pkg::S_INIT);
	assign seg_room  = (total_q < NW'(gmr_pkg::MAX_SEGMENTS));

	always_ff @(posedge clk) begin
		if (obs_we) begin
			obs_mem[obs_waddr] <= obs_wdata;
		end
		obs_rd_q <= obs_mem[rd_cell];
	end

	always_ff @(posedge clk) begin
		if (lab_we) begin
			lab_mem[lab_waddr] <= lab_wdata;
		end
		lab_rd_q <= lab_mem[rd_cell];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[tail_q[CW-1:0]] <= q_wdata;
		end
		q_rd_q <= q_mem[head_q[CW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[total_q[gmr_pkg::SEG_AW-1:0]] <= st_wdata;
		end
		st_rd_q <= st_mem[it_q.seg_index];
	end

	always_comb begin
		if (state_q == gmr_pkg::S_FNBR) begin
			base_r = cur_q[CW-1:DW];
			base_c = cur_q[DW-1:0];
			case (k_q[1:0])
				2'd0:    dir = gmr_pkg::DIR_DOWN;
				2'd1:    dir = gmr_pkg::DIR_RIGHT;
				2'd2:    dir = gmr_pkg::DIR_UP;
				default: dir = gmr_pkg::DIR_LEFT;
			endcase
		end else begin
			base_r = r_q;
			base_c = c_q;
			dir    = gmr_pkg::dir_t'(k_q[1:0]);
		end
		nb_r = base_r;
		nb_c = base_c;
		case (dir)
			gmr_pkg::DIR_UP: begin
				nb_ok = (base_r != '0);
				nb_r  = base_r - DW'(1);
			end
			gmr_pkg::DIR_LEFT: begin
				nb_ok = (base_c != '0);
				nb_c  = base_c - DW'(1);
			end
			gmr_pkg::DIR_DOWN: begin
				nb_ok = (({1'b0, base_r} + (DW + 1)'(1)) < h);
				nb_r  = base_r + DW'(1);
			end
			default: begin
				nb_ok = (({1'b0, base_c} + (DW + 1)'(1)) < w);
				nb_c  = base_c + DW'(1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gmr_pkg::S_INIT;
			cnt_q    <= '0;
			stored_q <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			total_q  <= '0;
			found_q  <= 1'b0;
			ovf_q    <= 1'b0;
			k_q      <= '0;
			guard_q  <= '0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			stored_q <= stored_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			total_q  <= total_d;
			found_q  <= found_d;
			ovf_q    <= ovf_d;
			k_q      <= k_d;
			guard_q  <= guard_d;
		end
	end

	always_ff @(posedge clk) begin
		it_q   <= it_d;
		res_q  <= res_d;
		seg_q  <= seg_d;
		cur_q  <= cur_d;
		n_q    <= n_d;
		nl_q   <= nl_d;
		want_q <= want_d;
		r_q    <= r_d;
		c_q    <= c_d;
		pr_q   <= pr_d;
		pc_q   <= pc_d;
	end

	always_comb begin
		state_d  = state_q;
		it_d     = it_q;
		res_d    = res_q;
		seg_d    = seg_q;
		cnt_d    = cnt_q;
		cur_d    = cur_q;
		n_d      = n_q;
		head_d   = head_q;
		tail_d   = tail_q;
		guard_d  = guard_q;
		nl_d     = nl_q;
		want_d   = want_q;
		k_d      = k_q;
		r_d      = r_q;
		c_d      = c_q;
		pr_d     = pr_q;
		pc_d     = pc_q;
		total_d  = total_q;
		stored_d = stored_q;
		found_d  = found_q;
		ovf_d    = ovf_q;

		obs_we    = 1'b0;
		obs_waddr = cnt_q;
		obs_wdata = 1'b0;
		lab_we    = 1'b0;
		lab_waddr = cnt_q;
		lab_wdata = gmr_pkg::LAB_NONE;
		q_we      = 1'b0;
		q_wdata   = n_q;
		st_we     = 1'b0;
		st_wdata  = seg_q;
		rd_cell   = n_q;
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		res_data  = res_q;
		res_data.count = stored_q;

		case (state_q)
			gmr_pkg::S_INIT, gmr_pkg::S_CLEAR: begin
				obs_we = 1'b1;
				cnt_d  = cnt_q + CW'(1);
				if (cnt_q == '1) begin
					state_d = (state_q == gmr_pkg::S_INIT) ? gmr_pkg::S_IDLE
						: gmr_pkg::S_RES;
				end
			end
			gmr_pkg::S_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop      = 1'b1;
					it_d         = cmd_item;
					res_d.status = gmr_pkg::ST_OK;
					res_d.count  = '0;
					res_d.seg    = '0;
					cnt_d        = '0;
					r_d          = cmd_item.ra;
					c_d          = cmd_item.ca;
					case (cmd_item.op)
						gmr_pkg::CMD_CLEAR: state_d = gmr_pkg::S_CLEAR;
						gmr_pkg::CMD_BLOCK: begin
							state_d = cmd_item.blk_empty ? gmr_pkg::S_RES
								: gmr_pkg::S_BLOCK;
						end
						gmr_pkg::CMD_ROUTE: begin
							if (cmd_item.pin_bad) begin
								res_d.status = gmr_pkg::ST_PIN_OUT;
								state_d      = gmr_pkg::S_RES;
							end else begin
								state_d = gmr_pkg::S_LCLR;
							end
						end
						default: begin
							if ({1'b0, cmd_item.seg_index} < stored_q) begin
								state_d = gmr_pkg::S_RDA;
							end else begin
								res_d.status = gmr_pkg::ST_BAD_INDEX;
								state_d      = gmr_pkg::S_RES;
							end
						end
					endcase
				end
			end
			gmr_pkg::S_BLOCK: begin
				obs_we    = 1'b1;
				obs_waddr = {r_q, c_q};
				obs_wdata = 1'b1;
				if (({1'b0, c_q} + (DW + 1)'(1)) < it_q.ce) begin
					c_d = c_q + DW'(1);
				end else begin
					c_d = it_q.ca;
					if (({1'b0, r_q} + (DW + 1)'(1)) < it_q.re) begin
						r_d = r_q + DW'(1);
					end else begin
						state_d = gmr_pkg::S_RES;
					end
				end
			end
			gmr_pkg::S_LCLR: begin
				lab_we = 1'b1;
				cnt_d  = cnt_q + CW'(1);
				tail_d = '0;
				if (cnt_q == '1) begin
					state_d = gmr_pkg::S_SEED;
				end
			end
			gmr_pkg::S_SEED: begin
				lab_we    = 1'b1;
				lab_waddr = src;
				lab_wdata = 2'd0;
				q_we      = 1'b1;
				q_wdata   = src;
				tail_d    = PW'(1);
				head_d    = '0;
				found_d   = (src == dst);
				state_d   = gmr_pkg::S_FPOP;
			end
			gmr_pkg::S_FPOP: begin
				if (found_q || (head_q >= tail_q)) begin
					state_d = gmr_pkg::S_MARK;
				end else begin
					head_d  = head_q + PW'(1);
					state_d = gmr_pkg::S_FCUR;
				end
			end
			gmr_pkg::S_FCUR: begin
				cur_d   = q_rd_q;
				rd_cell = q_rd_q;
				state_d = gmr_pkg::S_FLAB;
			end
			gmr_pkg::S_FLAB: begin
				nl_d    = gmr_pkg::lab_next(lab_rd_q);
				k_d     = '0;
				state_d = gmr_pkg::S_FNBR;
			end
			gmr_pkg::S_FNBR: begin
				if (k_q[2]) begin
					state_d = gmr_pkg::S_FPOP;
				end else if (!nb_ok) begin
					k_d = k_q + 3'd1;
				end else begin
					n_d     = {nb_r, nb_c};
					rd_cell = {nb_r, nb_c};
					state_d = gmr_pkg::S_FCHK;
				end
			end
			gmr_pkg::S_FCHK: begin
				if ((lab_rd_q == gmr_pkg::LAB_NONE)
					&& (!obs_rd_q || (n_q == src) || (n_q == dst))) begin
					lab_we    = 1'b1;
					lab_waddr = n_q;
					lab_wdata = nl_q;
					q_we      = 1'b1;
					tail_d    = tail_q + PW'(1);
				end
				if (n_q == dst) begin
					found_d = 1'b1;
					state_d = gmr_pkg::S_FPOP;
				end else begin
					k_d     = k_q + 3'd1;
					state_d = gmr_pkg::S_FNBR;
				end
			end
			gmr_pkg::S_MARK: begin
				obs_we    = 1'b1;
				obs_waddr = dst;
				obs_wdata = 1'b1;
				total_d   = '0;
				ovf_d     = 1'b0;
				seg_d     = '{sr: it_q.rb, sc: it_q.cb, er: it_q.rb, ec: it_q.cb};
				r_d       = it_q.rb;
				c_d       = it_q.cb;
				pr_d      = it_q.rb;
				pc_d      = it_q.cb;
				guard_d   = '0;
				state_d   = found_q ? gmr_pkg::S_BTL : gmr_pkg::S_FIN;
			end
			gmr_pkg::S_BTL: begin
				rd_cell = {r_q, c_q};
				if (({r_q, c_q} == src) || (guard_q == PW'(gmr_pkg::CELL_COUNT))) begin
					state_d = gmr_pkg::S_FIN;
				end else begin
					state_d = gmr_pkg::S_BTW;
				end
			end
			gmr_pkg::S_BTW: begin
				want_d  = gmr_pkg::lab_prev(lab_rd_q);
				guard_d = guard_q + PW'(1);
				k_d     = '0;
				state_d = gmr_pkg::S_BTN;
			end
			gmr_pkg::S_BTN: begin
				if (k_q[2]) begin
					state_d = gmr_pkg::S_FIN;
				end else if (!nb_ok) begin
					k_d = k_q + 3'd1;
				end else begin
					n_d     = {nb_r, nb_c};
					rd_cell = {nb_r, nb_c};
					state_d = gmr_pkg::S_BTC;
				end
			end
			gmr_pkg::S_BTC: begin
				if (lab_rd_q == want_q) begin
					r_d       = n_q[CW-1:DW];
					c_d       = n_q[DW-1:0];
					obs_we    = 1'b1;
					obs_waddr = n_q;
					obs_wdata = 1'b1;
					if ((pr_q == n_q[CW-1:DW]) || (pc_q == n_q[DW-1:0])) begin
						seg_d.er = n_q[CW-1:DW];
						seg_d.ec = n_q[DW-1:0];
					end else begin
						if (seg_room) begin
							st_we   = 1'b1;
							total_d = total_q + NW'(1);
						end else begin
							ovf_d = 1'b1;
						end
						pr_d  = seg_q.er;
						pc_d  = seg_q.ec;
						seg_d = '{sr: seg_q.er, sc: seg_q.ec,
							er: n_q[CW-1:DW], ec: n_q[DW-1:0]};
					end
					state_d = gmr_pkg::S_BTL;
				end else begin
					k_d     = k_q + 3'd1;
					state_d = gmr_pkg::S_BTN;
				end
			end
			gmr_pkg::S_FIN: begin
				if (seg_room) begin
					st_we    = 1'b1;
					stored_d = total_q + NW'(1);
				end else begin
					stored_d = total_q;
				end
				if (!found_q) begin
					res_d.status = gmr_pkg::ST_NO_ROUTE;
				end else if (ovf_q || !seg_room) begin
					res_d.status = gmr_pkg::ST_TRUNC;
				end else begin
					res_d.status = gmr_pkg::ST_OK;
				end
				state_d = gmr_pkg::S_RES;
			end
			gmr_pkg::S_RDA: begin
				state_d = gmr_pkg::S_RDW;
			end
			gmr_pkg::S_RDW: begin
				res_d.seg = st_rd_q;
				state_d   = gmr_pkg::S_RES;
			end
			gmr_pkg::S_RES: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = gmr_pkg::S_IDLE;
				end
			end
			default: state_d = gmr_pkg::S_IDLE;
		endcase
	end
endmodule

>>> dv/grid_maze_router_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the grid maze router: directed and random commands, queue handshakes.
module grid_maze_router_tb;

	typedef struct {
		gmr_pkg::cmd_t op;
		logic [5:0]    ra, ca, rb, cb;
		logic [6:0]    nr, nc;
		logic [7:0]    si;
	} router_cmd_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [1:0] command = '0;
	logic [5:0] row_a = '0, col_a = '0, row_b = '0, col_b = '0;
	logic [6:0] rect_rows = '0, rect_cols = '0;
	logic [7:0] seg_index = '0;
	logic       empty;
	logic       pop = 1'b0;
	logic [2:0] status;
	logic [8:0] segment_count;
	logic [5:0] seg_start_row, seg_start_col, seg_end_row, seg_end_col;
	logic       cfg_write = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;

	router_cmd_t   pending_cmds[$];
	gmr_pkg::res_t expected_results[$];
	int            errors = 0;
	bit            quiet = 1'b0;
	int            push_gap = 0, pop_gap = 0;

	// shadow state of the router
	bit            obst[gmr_pkg::CELL_COUNT];
	logic [1:0]    wave[gmr_pkg::CELL_COUNT];
	int            frontier[gmr_pkg::CELL_COUNT];
	gmr_pkg::seg_t seg_mem[gmr_pkg::MAX_SEGMENTS];
	int            seg_stored = 0;
	int            seg_total;
	bit            seg_over;
	int            cfg_height = 64, cfg_width = 64, cfg_label = 0;

	grid_maze_router dut (.*);

	initial forever #2 clk = ~clk;

	function automatic int clamp_dim(input int v);
		return (v == 0) ? 1 : ((v > gmr_pkg::DIM) ? gmr_pkg::DIM : v);
	endfunction

	function automatic void store_seg(input gmr_pkg::seg_t s);
		if (seg_total < gmr_pkg::MAX_SEGMENTS) begin
			seg_mem[seg_total] = s;
			seg_total++;
		end else begin
			seg_over = 1'b1;
		end
	endfunction

	function automatic bit open_cell(input int n, input int src, input int dst);
		if (wave[n] != gmr_pkg::LAB_NONE) return 1'b0;
		return !obst[n] || n == src || n == dst;
	endfunction

	function automatic gmr_pkg::status_t route_net(input int sr, input int sc, input int dr,
			input int dc, input int h, input int w);
		int src, dst, head, tail, cur, r, c, cnt, n, pr, pc, guard, idx;
		int nb[4];
		logic [1:0] nl, want;
		bit found;
		gmr_pkg::seg_t cs;
		src = sr * gmr_pkg::DIM + sc;
		dst = dr * gmr_pkg::DIM + dc;
		head = 0;
		tail = 0;
		found = (src == dst);
		foreach (wave[i]) wave[i] = gmr_pkg::LAB_NONE;
		wave[src] = 2'd0;
		frontier[tail++] = src;
		while (!found && head < tail) begin
			cur = frontier[head++];
			r = cur / gmr_pkg::DIM;
			c = cur % gmr_pkg::DIM;
			nl = 2'((wave[cur] + 1) % 3);
			cnt = 0;
			if (r + 1 < h) nb[cnt++] = cur + gmr_pkg::DIM;
			if (c + 1 < w) nb[cnt++] = cur + 1;
			if (r > 0) nb[cnt++] = cur - gmr_pkg::DIM;
			if (c > 0) nb[cnt++] = cur - 1;
			for (int k = 0; k < cnt; k++) begin
				n = nb[k];
				if (open_cell(n, src, dst) && tail < gmr_pkg::CELL_COUNT) begin
					wave[n] = nl;
					frontier[tail++] = n;
				end
				if (n == dst) begin
					found = 1'b1;
					break;
				end
			end
		end
		seg_total = 0;
		seg_over = 1'b0;
		cs.sr = 6'(dr); cs.sc = 6'(dc); cs.er = 6'(dr); cs.ec = 6'(dc);
		obst[dst] = 1'b1;
		if (!found) begin
			store_seg(cs);
			seg_stored = seg_total;
			return gmr_pkg::ST_NO_ROUTE;
		end
		r = dr; c = dc; pr = dr; pc = dc; guard = 0;
		while ((r != sr || c != sc) && guard < gmr_pkg::CELL_COUNT) begin
			idx = r * gmr_pkg::DIM + c;
			want = 2'((wave[idx] + 2) % 3);
			guard++;
			if (r > 0 && wave[idx - gmr_pkg::DIM] == want) r--;
			else if (c > 0 && wave[idx - 1] == want) c--;
			else if (r + 1 < h && wave[idx + gmr_pkg::DIM] == want) r++;
			else if (c + 1 < w && wave[idx + 1] == want) c++;
			else break;
			obst[r * gmr_pkg::DIM + c] = 1'b1;
			if (pr == r || pc == c) begin
				cs.er = 6'(r); cs.ec = 6'(c);
			end else begin
				store_seg(cs);
				pr = cs.er; pc = cs.ec;
				cs.sr = 6'(pr); cs.sc = 6'(pc); cs.er = 6'(r); cs.ec = 6'(c);
			end
		end
		store_seg(cs);
		seg_stored = seg_total;
		return seg_over ? gmr_pkg::ST_TRUNC : gmr_pkg::ST_OK;
	endfunction

	function automatic gmr_pkg::res_t run_command(input router_cmd_t it);
		gmr_pkg::res_t res;
		int h, w, re, ce;
		h = clamp_dim(cfg_height);
		w = clamp_dim(cfg_width);
		res = '0;
		res.status = gmr_pkg::ST_OK;
		case (it.op)
			gmr_pkg::CMD_CLEAR: begin
				foreach (obst[i]) obst[i] = 1'b0;
			end
			gmr_pkg::CMD_BLOCK: begin
				if (it.ra < h && it.ca < w) begin
					re = it.ra + it.nr;
					ce = it.ca + it.nc;
					if (re > h) re = h;
					if (ce > w) ce = w;
					for (int r = it.ra; r < re; r++)
						for (int c = it.ca; c < ce; c++)
							obst[r * gmr_pkg::DIM + c] = 1'b1;
				end
			end
			gmr_pkg::CMD_ROUTE: begin
				if (it.ra >= h || it.ca >= w || it.rb >= h || it.cb >= w)
					res.status = gmr_pkg::ST_PIN_OUT;
				else
					res.status = route_net(it.ra, it.ca, it.rb, it.cb, h, w);
			end
			default: begin
				if (it.si < seg_stored) res.seg = seg_mem[it.si];
				else res.status = gmr_pkg::ST_BAD_INDEX;
			end
		endcase
		res.count = 9'(seg_stored);
		return res;
	endfunction

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (push_gap > 0) begin
			push_gap <= push_gap - 1;
			push <= 1'b0;
		end else if (pending_cmds.size() == 0) begin
			push <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			push_gap <= $urandom_range(0, 4);
			push <= 1'b0;
		end else begin
			push <= 1'b1;
			command <= pending_cmds[0].op;
			row_a <= pending_cmds[0].ra;
			col_a <= pending_cmds[0].ca;
			row_b <= pending_cmds[0].rb;
			col_b <= pending_cmds[0].cb;
			rect_rows <= pending_cmds[0].nr;
			rect_cols <= pending_cmds[0].nc;
			seg_index <= pending_cmds[0].si;
		end
		if (pop_gap > 0) begin
			pop_gap <= pop_gap - 1;
			pop <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			pop_gap <= $urandom_range(0, 4);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		gmr_pkg::res_t exp_r;
		router_cmd_t   acc_cmd;
		if (push && !full && pending_cmds.size() != 0) begin
			acc_cmd = pending_cmds.pop_front();
			expected_results.insert(expected_results.size(), run_command(acc_cmd));
		end
		if (pop && !empty) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				check_field("status", exp_r.status, status);
				check_field("segment_count", exp_r.count, segment_count);
				check_field("seg_start_row", exp_r.seg.sr, seg_start_row);
				check_field("seg_start_col", exp_r.seg.sc, seg_start_col);
				check_field("seg_end_row", exp_r.seg.er, seg_end_row);
				check_field("seg_end_col", exp_r.seg.ec, seg_end_col);
			end
		end
	end

	task automatic add_cmd(input gmr_pkg::cmd_t op, input int ra, input int ca, input int rb,
			input int cb, input int nr, input int nc, input int si);
		router_cmd_t it;
		it.op = op; it.ra = 6'(ra); it.ca = 6'(ca); it.rb = 6'(rb); it.cb = 6'(cb);
		it.nr = 7'(nr); it.nc = 7'(nc); it.si = 8'(si);
		pending_cmds.insert(pending_cmds.size(), it);
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input gmr_pkg::reg_idx_t idx, input int v);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 7'(v);
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			gmr_pkg::REG_GRID_HEIGHT: cfg_height = v & 'h7f;
			gmr_pkg::REG_GRID_WIDTH:  cfg_width = v & 'h7f;
			gmr_pkg::REG_SPARE_A:     cfg_label = v & 'h3;
			default: ;
		endcase
	endtask

	function automatic int pick_coord(input int lim);
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 63);
		return $urandom_range(0, lim - 1);
	endfunction

	task automatic add_random(input int n);
		int h, w, sel;
		h = clamp_dim(cfg_height);
		w = clamp_dim(cfg_width);
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 5)
				add_cmd(gmr_pkg::CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 255));
			else if (sel < 40)
				add_cmd(gmr_pkg::CMD_BLOCK, pick_coord(h), pick_coord(w),
					$urandom_range(0, 63), $urandom_range(0, 63),
					($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 3),
					($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 3),
					$urandom_range(0, 255));
			else if (sel < 75)
				add_cmd(gmr_pkg::CMD_ROUTE, pick_coord(h), pick_coord(w), pick_coord(h),
					pick_coord(w),
					$urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 255));
			else
				add_cmd(gmr_pkg::CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 127), $urandom_range(0, 127),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7));
		end
	endtask

	initial begin
		foreach (obst[i]) obst[i] = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_cmd(gmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0);
		add_cmd(gmr_pkg::CMD_ROUTE, 0, 0, 63, 63, 0, 0, 0);
		add_cmd(gmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0);
		add_cmd(gmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 1);
		add_cmd(gmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 255);
		add_cmd(gmr_pkg::CMD_ROUTE, 5, 5, 5, 5, 0, 0, 0);
		add_cmd(gmr_pkg::CMD_BLOCK, 60, 60, 0, 0, 64, 64, 0);
		add_cmd(gmr_pkg::CMD_ROUTE, 62, 62, 2, 10, 0, 0, 0);
		add_cmd(gmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 1);
		add_cmd(gmr_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		add_cmd(gmr_pkg::CMD_BLOCK, 0, 30, 0, 0, 64, 1, 0);
		add_cmd(gmr_pkg::CMD_BLOCK, 20, 20, 0, 0, 0, 5, 0);
		add_cmd(gmr_pkg::CMD_ROUTE, 0, 0, 0, 40, 0, 0, 0);
		add_cmd(gmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0);
		add_cmd(gmr_pkg::CMD_BLOCK, 3, 3, 0, 0, 1, 1, 0);
		add_cmd(gmr_pkg::CMD_ROUTE, 3, 3, 3, 10, 0, 0, 0);
		add_cmd(gmr_pkg::CMD_ROUTE, 0, 0, 63, 0, 0, 0, 0);
		drain();

		write_reg(gmr_pkg::REG_GRID_HEIGHT, 8);
		write_reg(gmr_pkg::REG_GRID_WIDTH, 6);
		write_reg(gmr_pkg::REG_SPARE_A, 3);
		add_cmd(gmr_pkg::CMD_CLEAR, 63, 63, 63, 63, 127, 127, 255);
		add_cmd(gmr_pkg::CMD_BLOCK, 9, 1, 0, 0, 2, 2, 0);
		add_cmd(gmr_pkg::CMD_ROUTE, 0, 0, 7, 9, 0, 0, 0);
		add_cmd(gmr_pkg::CMD_ROUTE, 0, 0, 7, 5, 0, 0, 0);
		add_cmd(gmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0);
		drain();

		write_reg(gmr_pkg::REG_GRID_HEIGHT, 0);
		write_reg(gmr_pkg::REG_GRID_WIDTH, 127);
		write_reg(gmr_pkg::REG_SPARE_A, 1);
		add_cmd(gmr_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		add_cmd(gmr_pkg::CMD_ROUTE, 0, 0, 0, 63, 0, 0, 0);
		add_cmd(gmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0);
		add_random(12);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(gmr_pkg::REG_GRID_HEIGHT, ($urandom_range(0, 5) == 0) ?
				$urandom_range(0, 127) : $urandom_range(2, 14));
			write_reg(gmr_pkg::REG_GRID_WIDTH, ($urandom_range(0, 5) == 0) ?
				$urandom_range(0, 127) : $urandom_range(2, 14));
			write_reg(gmr_pkg::REG_SPARE_A, $urandom_range(0, 2));
			quiet = (ph == 4);
			add_random(12);
			drain();
		end

		write_reg(gmr_pkg::REG_GRID_HEIGHT, 1);
		write_reg(gmr_pkg::REG_GRID_WIDTH, 1);
		write_reg(gmr_pkg::REG_SPARE_A, 2);
		add_cmd(gmr_pkg::CMD_ROUTE, 0, 0, 0, 0, 0, 0, 0);
		add_cmd(gmr_pkg::CMD_ROUTE, 1, 0, 0, 0, 0, 0, 0);
		add_cmd(gmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0);
		drain();
		repeat (50) @(posedge clk);

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#400_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
